>>> sv/spcs_pkg.sv
// Shared types and constants for the strict-priority call scheduler.
// Used by spcs_ctrl, spcs_datapath and strict_priority_call_scheduler.
package spcs_pkg;

  // Default sizing for the top-level parameters
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int NUM_CLASSES_DEF = 4;

  // Fixed field widths
  localparam int ID_W   = 16;
  localparam int DUR_W  = 16;
  localparam int LVL_W  = 2;
  localparam int TICK_W = 32;
  localparam int ENTRY_W = ID_W + DUR_W;

  // Input command codes
  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_TICK,
    ST_FETCH,
    ST_DISPATCH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // load the input item
    logic arrive;     // enqueue or drop, load arrival result
    logic select;     // latch the highest non-empty class
    logic read;       // read the head entry of the latched class
    logic idle_tick;  // tick without dispatch, load result
    logic dispatch;   // dequeue head, load busy counter, load result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic item_tick;     // captured item is a tick
    logic can_dispatch;  // server free and some class waiting
    logic out_free;      // result register can take a new result
  } dp_status_t;

endpackage

>>> sv/spcs_ctrl.sv
// Controller state machine of the strict-priority call scheduler.
// Depends on spcs_pkg for the state enum and the command/status structs.
module spcs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  spcs_pkg::dp_status_t status,
  output spcs_pkg::dp_cmd_t    dp_cmd
);

  spcs_pkg::state_t state;
  spcs_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    in_ready   = 1'b0;
    case (state)
      spcs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.capture = 1'b1;
          state_next     = spcs_pkg::ST_TICK;
          if (!status.item_tick) begin
            state_next = spcs_pkg::ST_ARRIVE;
          end
        end
      end
      spcs_pkg::ST_ARRIVE: begin
        if (status.out_free) begin
          dp_cmd.arrive = 1'b1;
          state_next    = spcs_pkg::ST_IDLE;
        end
      end
      spcs_pkg::ST_TICK: begin
        if (status.can_dispatch) begin
          dp_cmd.select = 1'b1;
          state_next    = spcs_pkg::ST_FETCH;
        end else if (status.out_free) begin
          dp_cmd.idle_tick = 1'b1;
          state_next       = spcs_pkg::ST_IDLE;
        end
      end
      spcs_pkg::ST_FETCH: begin
        dp_cmd.read = 1'b1;
        state_next  = spcs_pkg::ST_DISPATCH;
      end
      spcs_pkg::ST_DISPATCH: begin
        if (status.out_free) begin
          dp_cmd.dispatch = 1'b1;
          state_next      = spcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spcs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/spcs_datapath.sv
// Datapath of the strict-priority call scheduler: class FIFOs in one memory,
// busy and tick counters, result register. Depends on spcs_pkg.
module spcs_datapath #(
  parameter int QUEUE_DEPTH = spcs_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_CLASSES = spcs_pkg::NUM_CLASSES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  spcs_pkg::dp_cmd_t             dp_cmd,
  output spcs_pkg::dp_status_t          status,
  input  logic                          cmd,
  input  logic [spcs_pkg::ID_W-1:0]     caller_id,
  input  logic [spcs_pkg::LVL_W-1:0]    level,
  input  logic [spcs_pkg::DUR_W-1:0]    duration,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          answered,
  output logic [spcs_pkg::ID_W-1:0]     answered_id,
  output logic [spcs_pkg::LVL_W-1:0]    answered_level,
  output logic [spcs_pkg::TICK_W-1:0]   tick_number,
  output logic                          dropped,
  output logic                          server_busy
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int CW = $clog2(NUM_CLASSES);
  localparam int MEM_DEPTH = NUM_CLASSES << PW;

  // Captured item
  logic                       item_cmd;
  logic [spcs_pkg::ID_W-1:0]  item_id;
  logic [spcs_pkg::LVL_W-1:0] item_level;
  logic [spcs_pkg::DUR_W-1:0] item_dur;

  // Queue state
  logic [spcs_pkg::ENTRY_W-1:0] store [MEM_DEPTH];
  logic [spcs_pkg::ENTRY_W-1:0] rd_data;
  logic [PW-1:0]                head [NUM_CLASSES];
  logic [FW-1:0]                fill [NUM_CLASSES];
  logic [CW-1:0]                sel_cls;
  logic [spcs_pkg::DUR_W-1:0]   busy_left;
  logic [spcs_pkg::TICK_W-1:0]  tick_count;

  // Combinational helpers
  logic [CW-1:0]              arr_cls;
  logic [CW-1:0]              idx;
  logic [CW-1:0]              pe_cls;
  logic                       any_waiting;
  logic                       full;
  logic [PW:0]                slot_sum;
  logic [PW-1:0]              slot;
  logic [PW-1:0]              head_inc;
  logic [spcs_pkg::DUR_W-1:0] busy_dec;
  logic [spcs_pkg::DUR_W-1:0] rd_dur;
  logic [spcs_pkg::DUR_W-1:0] busy_load;
  logic                       out_free;

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      item_cmd   <= spcs_pkg::CMD_ARRIVAL;
      item_id    <= '0;
      item_level <= '0;
      item_dur   <= '0;
    end else if (dp_cmd.capture) begin
      item_cmd   <= cmd;
      item_id    <= caller_id;
      item_level <= level;
      item_dur   <= duration;
    end
  end

  // Map the arrival level onto the implemented classes
  always_comb begin
    arr_cls = CW'(item_level);
    if (int'(item_level) >= NUM_CLASSES) begin
      arr_cls = CW'(NUM_CLASSES - 1);
    end
  end

  assign idx = (item_cmd == spcs_pkg::CMD_TICK) ? sel_cls : arr_cls;

  // Find the highest non-empty class
  always_comb begin
    pe_cls      = '0;
    any_waiting = 1'b0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (fill[c] != '0) begin
        pe_cls      = CW'(c);
        any_waiting = 1'b1;
      end
    end
  end

  // Slot and pointer arithmetic for the indexed class
  always_comb begin
    full     = (fill[idx] == FW'(QUEUE_DEPTH));
    slot_sum = (PW+1)'(head[idx]) + (PW+1)'(fill[idx]);
    slot     = PW'(slot_sum);
    if (slot_sum >= (PW+1)'(QUEUE_DEPTH)) begin
      slot = PW'(slot_sum - (PW+1)'(QUEUE_DEPTH));
    end
    head_inc = head[idx] + PW'(1);
    if (head[idx] == PW'(QUEUE_DEPTH - 1)) begin
      head_inc = '0;
    end
  end

  // Busy counter values
  assign busy_dec  = (busy_left != '0) ? busy_left - 1'b1 : '0;
  assign rd_dur    = rd_data[spcs_pkg::ENTRY_W-1:spcs_pkg::ID_W];
  assign busy_load = (rd_dur != '0) ? rd_dur - 1'b1 : '0;

  // Request memory: write on enqueue, registered read of a head entry
  always_ff @(posedge clk) begin
    if (dp_cmd.arrive && !full) begin
      store[{idx, slot}] <= {item_dur, item_id};
    end
    if (dp_cmd.read) begin
      rd_data <= store[{idx, head[idx]}];
    end
  end

  // Latch the class picked for dispatch
  always_ff @(posedge clk) begin
    if (rst) begin
      sel_cls <= '0;
    end else if (dp_cmd.select) begin
      sel_cls <= pe_cls;
    end
  end

  // Head pointers and fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c] <= '0;
        fill[c] <= '0;
      end
    end else if (dp_cmd.arrive && !full) begin
      fill[idx] <= fill[idx] + FW'(1);
    end else if (dp_cmd.dispatch) begin
      head[idx] <= head_inc;
      fill[idx] <= fill[idx] - FW'(1);
    end
  end

  // Busy and tick counters
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_left  <= '0;
      tick_count <= '0;
    end else if (dp_cmd.idle_tick) begin
      busy_left  <= busy_dec;
      tick_count <= tick_count + 1'b1;
    end else if (dp_cmd.dispatch) begin
      busy_left  <= busy_load;
      tick_count <= tick_count + 1'b1;
    end
  end

  // Result valid: set on load, drop on transfer
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.arrive || dp_cmd.idle_tick || dp_cmd.dispatch) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (dp_cmd.arrive) begin
      answered       <= 1'b0;
      answered_id    <= '0;
      answered_level <= '0;
      tick_number    <= tick_count;
      dropped        <= full;
      server_busy    <= (busy_left != '0);
    end else if (dp_cmd.idle_tick) begin
      answered       <= 1'b0;
      answered_id    <= '0;
      answered_level <= '0;
      tick_number    <= tick_count;
      dropped        <= 1'b0;
      server_busy    <= (busy_dec != '0);
    end else if (dp_cmd.dispatch) begin
      answered       <= 1'b1;
      answered_id    <= rd_data[spcs_pkg::ID_W-1:0];
      answered_level <= spcs_pkg::LVL_W'(sel_cls);
      tick_number    <= tick_count;
      dropped        <= 1'b0;
      server_busy    <= (busy_load != '0);
    end
  end

  // Status to the controller
  assign status.item_tick    = (cmd == spcs_pkg::CMD_TICK);
  assign status.can_dispatch = (busy_left == '0) && any_waiting;
  assign status.out_free     = out_free;

  // Fill count of the indexed class never passes the queue depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill[idx] <= FW'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  // Dispatch only with the server free and the class non-empty
  a_dispatch_ok: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.dispatch |-> (busy_left == '0) && (fill[idx] != '0))
    else $error("dispatch with busy server or empty class");

  // Never overwrite a result that has not been taken
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (dp_cmd.arrive || dp_cmd.idle_tick || dp_cmd.dispatch) |-> out_free)
    else $error("result register overrun");

  // Each tick result advances the tick counter by one
  a_tick_step: assert property (@(posedge clk) disable iff (rst)
    (dp_cmd.idle_tick || dp_cmd.dispatch) |=> tick_count == $past(tick_count) + 1'b1)
    else $error("tick counter did not advance");

endmodule

>>> sv/strict_priority_call_scheduler.sv
// Top level of the strict-priority call scheduler.
// Depends on spcs_pkg, spcs_ctrl and spcs_datapath.
//
// Usage: one input channel (in_valid/in_ready) carries items: cmd 0 is a
// request arrival (caller_id, level, duration) queued into the FIFO of its
// class; cmd 1 is one time tick. Every item yields exactly one result on
// the output channel (out_valid/out_ready).
// Timing: an arrival or a tick that dispatches nothing loads its result
// in the ARRIVE or TICK state entered at the input transfer; a dispatching
// tick steps through TICK, FETCH and DISPATCH (select the class, read
// the head entry from the request memory, then load the result). The
// controller handles one item at a time: in_ready is high only in IDLE.
// The result register lets the next item transfer in while a result waits.
// Reset: queues are empty, busy and tick counters are zero, no result is
// pending; the request memory is not cleared and needs no sweep.
// Stall: while out_ready is low the finished result holds, and the item in
// work waits before loading its result until the register frees up.
module strict_priority_call_scheduler #(
  parameter int QUEUE_DEPTH = spcs_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_CLASSES = spcs_pkg::NUM_CLASSES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [spcs_pkg::ID_W-1:0]     caller_id,
  input  logic [spcs_pkg::LVL_W-1:0]    level,
  input  logic [spcs_pkg::DUR_W-1:0]    duration,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          answered,
  output logic [spcs_pkg::ID_W-1:0]     answered_id,
  output logic [spcs_pkg::LVL_W-1:0]    answered_level,
  output logic [spcs_pkg::TICK_W-1:0]   tick_number,
  output logic                          dropped,
  output logic                          server_busy
);

  spcs_pkg::dp_cmd_t    dp_cmd;
  spcs_pkg::dp_status_t status;

  // Sequencing of each item
  spcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .dp_cmd   (dp_cmd)
  );

  // Queues, counters and result register
  spcs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .dp_cmd         (dp_cmd),
    .status         (status),
    .cmd            (cmd),
    .caller_id      (caller_id),
    .level          (level),
    .duration       (duration),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .answered       (answered),
    .answered_id    (answered_id),
    .answered_level (answered_level),
    .tick_number    (tick_number),
    .dropped        (dropped),
    .server_busy    (server_busy)
  );

endmodule
